// File: hw/rtl/romix_pkg.sv
// Shared types, SHA-512 constants and helpers for the ROMix key derivation block.
`default_nettype none
package romix_pkg;

  typedef logic [63:0] word_t;
  typedef logic [7:0][63:0] state_t;
  typedef logic [15:0][63:0] block_t;

  localparam int unsigned SALT_BYTES = 32;

  localparam logic [2:0] CFG_SALT0 = 3'd0;
  localparam logic [2:0] CFG_SALT1 = 3'd1;
  localparam logic [2:0] CFG_SALT2 = 3'd2;
  localparam logic [2:0] CFG_SALT3 = 3'd3;
  localparam logic [2:0] CFG_SEQ   = 3'd4;
  localparam logic [2:0] CFG_ITER  = 3'd5;

  localparam state_t INIT_HASH = {
    64'h5be0cd19137e2179, 64'h1f83d9abfb41bd6b, 64'h9b05688c2b3e6c1f, 64'h510e527fade682d1,
    64'ha54ff53a5f1d36f1, 64'h3c6ef372fe94f82b, 64'hbb67ae8584caa73b, 64'h6a09e667f3bcc908
  };

  localparam word_t K_TAB [0:79] = '{
    64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
    64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
    64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
    64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
    64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
    64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
    64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
    64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
    64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
    64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
    64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
    64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
    64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
    64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
    64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
    64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
    64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
    64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
    64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
    64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
  };

  function automatic word_t rotr(word_t x, int unsigned n);
    return (x >> n) | (x << (64 - n));
  endfunction

  // one-block message of exactly 64 bytes
  function automatic block_t pad64(state_t x);
    block_t b;
    b = '0;
    b[7:0] = x;
    b[8] = 64'h8000000000000000;
    b[15] = 64'd512;
    return b;
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/romix_sha512_key_derivation_top.sv
// Top level: password streaming, SHA-512 padding and the ROMix table sequencer.
//
//  channel | signals                                         | dir
//  in      | in_valid, in_stall, has_byte, password_byte,    | in
//          | end_of_password                                 |
//  out     | out_valid, out_stall, key_word, word_index,     | out
//          | last_word                                       |
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data       | in
//
// Every 128th password byte starts a compression of the block, with in_stall held high.
// The end marker starts a derivation whose length depends on iterations and n, and is
// set by the one shared compression unit (80 rounds, one per cycle) and the slot RAM port.
// Reset is synchronous and needs no clearing pass; the slot table is written before read.
// in_stall is high from the end marker until the fourth key word is taken.
`default_nettype none
module romix_sha512_key_derivation_top #(
  parameter int MAX_SEQUENCE = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        has_byte,
  input  wire logic [7:0]  password_byte,
  input  wire logic        end_of_password,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [63:0]      key_word,
  output logic [1:0]       word_index,
  output logic             last_word,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);
  import romix_pkg::*;

  localparam int NW = $clog2(MAX_SEQUENCE + 1);
  localparam int SW = (MAX_SEQUENCE > 1) ? $clog2(MAX_SEQUENCE) : 1;
  localparam int RAM_DEPTH = (2 ** SW) * 8;

  localparam logic [3:0] S_IN     = 4'd0;
  localparam logic [3:0] S_PUT    = 4'd1;
  localparam logic [3:0] S_HSTART = 4'd2;
  localparam logic [3:0] S_HWAIT  = 4'd3;
  localparam logic [3:0] S_ITER   = 4'd4;
  localparam logic [3:0] S_WR     = 4'd5;
  localparam logic [3:0] S_RND    = 4'd6;
  localparam logic [3:0] S_MOD    = 4'd7;
  localparam logic [3:0] S_RD     = 4'd8;
  localparam logic [3:0] S_RDL    = 4'd9;
  localparam logic [3:0] S_OUT    = 4'd10;

  localparam logic [1:0] PH_SALT = 2'd0;
  localparam logic [1:0] PH_PAD  = 2'd1;
  localparam logic [1:0] PH_ZERO = 2'd2;
  localparam logic [1:0] PH_LEN  = 2'd3;

  localparam logic [1:0] HR_STREAM = 2'd0;
  localparam logic [1:0] HR_FINAL  = 2'd1;
  localparam logic [1:0] HR_DERIV  = 2'd2;

  logic [3:0]       state;
  logic [3:0]       hnext;
  logic [1:0]       hret;
  logic [1:0]       ph;
  logic [4:0]       cnt;
  logic [3:0][63:0] salt;
  logic [10:0]      seq_cfg;
  logic [31:0]      iter_cfg;
  state_t           hash_state;
  block_t           blk;
  state_t           x;
  logic [63:0]      len;
  logic [63:0]      tot;
  logic [6:0]       pos;
  logic [NW-1:0]    n;
  logic [31:0]      iters;
  logic [31:0]      it;
  logic [NW-1:0]    s;
  logic [NW-1:0]    r;
  logic [2:0]       w;
  logic [SW-1:0]    idx;
  logic             rv;
  logic [2:0]       rw;
  logic [1:0]       k;

  logic             in_acc;
  logic             out_acc;
  logic             put_en;
  logic [7:0]       put_b;
  logic [127:0]     len_field;
  logic             core_start;
  logic             core_busy;
  logic             core_done;
  state_t           core_dig;
  logic             mod_start;
  logic             mod_done;
  logic [NW-1:0]    mod_rem;
  logic [31:0]      lo;
  logic             ram_we;
  logic [SW+2:0]    ram_waddr;
  logic [SW+2:0]    ram_raddr;
  logic [63:0]      ram_rdata;

  assign in_stall  = (state != S_IN);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = (state == S_OUT);
  assign out_acc   = out_valid && !out_stall;
  assign key_word  = x[k];
  assign word_index = k;
  assign last_word = (k == 2'd3);
  assign cfg_ready = 1'b1;

  assign len_field = {61'd0, tot, 3'd0};
  assign lo = x[7][31:0];

  always_comb begin
    put_en = 1'b0;
    put_b  = '0;
    if (state == S_PUT) begin
      unique case (ph)
        PH_SALT: begin
          put_en = 1'b1;
          put_b  = salt[cnt[4:3]][{~cnt[2:0], 3'd0} +: 8];
        end
        PH_PAD: begin
          put_en = 1'b1;
          put_b  = 8'h80;
        end
        PH_ZERO: begin
          put_en = (pos != 7'd112);
        end
        PH_LEN: begin
          put_en = 1'b1;
          put_b  = len_field[{~cnt[3:0], 3'd0} +: 8];
        end
        default: ;
      endcase
    end
  end

  assign core_start = (state == S_HSTART);
  assign mod_start  = (state == S_RND) && (r < (n >> 1));
  assign ram_we     = (state == S_WR);
  assign ram_waddr  = {s[SW-1:0], w};
  assign ram_raddr  = {idx, w};

  always_ff @(posedge clk) begin
    if (rst) begin
      salt     <= '0;
      seq_cfg  <= 11'd16;
      iter_cfg <= 32'd1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SALT0, CFG_SALT1, CFG_SALT2, CFG_SALT3: salt[cfg_index[1:0]] <= cfg_data;
        CFG_SEQ:  seq_cfg  <= cfg_data[10:0];
        CFG_ITER: iter_cfg <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    rv <= (state == S_RD);
    rw <= w;
    if (rst) begin
      state      <= S_IN;
      hash_state <= INIT_HASH;
      blk        <= '0;
      len        <= '0;
      pos        <= '0;
      ph         <= PH_SALT;
      cnt        <= '0;
      hret       <= HR_STREAM;
      hnext      <= S_IN;
      k          <= '0;
      it         <= '0;
      s          <= '0;
      r          <= '0;
      w          <= '0;
    end else begin
      if (rv) begin
        blk[rw] <= x[rw] ^ ram_rdata;
      end
      unique case (state)
        S_IN: begin
          if (in_acc) begin
            if (has_byte) begin
              blk[pos[6:3]][{~pos[2:0], 3'd0} +: 8] <= password_byte;
              pos <= pos + 7'd1;
              len <= len + 64'd1;
            end
            if (end_of_password) begin
              ph  <= PH_SALT;
              cnt <= '0;
              if (seq_cfg == '0) begin
                n <= NW'(1);
              end else if (32'(seq_cfg) > 32'(MAX_SEQUENCE)) begin
                n <= NW'(MAX_SEQUENCE);
              end else begin
                n <= NW'(seq_cfg);
              end
              iters <= (iter_cfg == '0) ? 32'd1 : iter_cfg;
            end
            if (has_byte && pos == 7'd127) begin
              hret  <= HR_STREAM;
              hnext <= end_of_password ? S_PUT : S_IN;
              state <= S_HSTART;
            end else if (end_of_password) begin
              state <= S_PUT;
            end
          end
        end
        S_PUT: begin
          if (put_en) begin
            blk[pos[6:3]][{~pos[2:0], 3'd0} +: 8] <= put_b;
            pos <= pos + 7'd1;
          end
          unique case (ph)
            PH_SALT: begin
              len <= len + 64'd1;
              cnt <= cnt + 5'd1;
              if (cnt == 5'(SALT_BYTES - 1)) begin
                ph <= PH_PAD;
              end
            end
            PH_PAD: begin
              tot <= len;
              ph  <= PH_ZERO;
            end
            PH_ZERO: begin
              if (pos == 7'd112) begin
                ph  <= PH_LEN;
                cnt <= '0;
              end
            end
            PH_LEN: cnt <= cnt + 5'd1;
            default: ;
          endcase
          if (put_en && pos == 7'd127) begin
            hret  <= (ph == PH_LEN) ? HR_FINAL : HR_STREAM;
            hnext <= S_PUT;
            state <= S_HSTART;
          end
        end
        S_HSTART: state <= S_HWAIT;
        S_HWAIT: begin
          if (core_done) begin
            case (hret)
              HR_STREAM: begin
                hash_state <= core_dig;
                blk        <= '0;
                state      <= hnext;
              end
              HR_FINAL: begin
                x          <= core_dig;
                hash_state <= INIT_HASH;
                blk        <= '0;
                len        <= '0;
                pos        <= '0;
                it         <= '0;
                state      <= S_ITER;
              end
              default: begin
                x     <= core_dig;
                state <= hnext;
              end
            endcase
          end
        end
        S_ITER: begin
          s <= '0;
          w <= '0;
          if (it != '0) begin
            blk   <= pad64({salt, x[3:0]});
            hret  <= HR_DERIV;
            hnext <= S_WR;
            state <= S_HSTART;
          end else begin
            state <= S_WR;
          end
        end
        S_WR: begin
          w <= w + 3'd1;
          if (w == 3'd7) begin
            if ({1'b0, s} + (NW+1)'(1) < {1'b0, n}) begin
              s     <= s + NW'(1);
              blk   <= pad64(x);
              hret  <= HR_DERIV;
              hnext <= S_WR;
              state <= S_HSTART;
            end else begin
              r     <= '0;
              state <= S_RND;
            end
          end
        end
        S_RND: begin
          if (mod_start) begin
            state <= S_MOD;
          end else if ({1'b0, it} + 33'd1 < {1'b0, iters}) begin
            it    <= it + 32'd1;
            state <= S_ITER;
          end else begin
            k     <= '0;
            state <= S_OUT;
          end
        end
        S_MOD: begin
          if (mod_done) begin
            idx   <= mod_rem[SW-1:0];
            w     <= '0;
            blk   <= pad64('0);
            state <= S_RD;
          end
        end
        S_RD: begin
          w <= w + 3'd1;
          if (w == 3'd7) begin
            state <= S_RDL;
          end
        end
        S_RDL: begin
          r     <= r + NW'(1);
          hret  <= HR_DERIV;
          hnext <= S_RND;
          state <= S_HSTART;
        end
        S_OUT: begin
          if (out_acc) begin
            k <= k + 2'd1;
            if (k == 2'd3) begin
              blk   <= '0;
              state <= S_IN;
            end
          end
        end
        default: state <= S_IN;
      endcase
    end
  end

  romix_sha u_sha (
    .clk    (clk),
    .rst    (rst),
    .start  (core_start),
    .st_in  (hash_state),
    .blk_in (blk),
    .busy   (core_busy),
    .done   (core_done),
    .digest (core_dig)
  );

  romix_mod #(
    .NW (NW)
  ) u_mod (
    .clk   (clk),
    .rst   (rst),
    .start (mod_start),
    .num   ({lo[7:0], lo[15:8], lo[23:16], lo[31:24]}),
    .den   (n),
    .done  (mod_done),
    .rem   (mod_rem)
  );

  romix_ram #(
    .WIDTH (64),
    .DEPTH (RAM_DEPTH)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (x[w]),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  a_core_idle: assert property (@(posedge clk) disable iff (rst) core_start |-> !core_busy)
    else $error("compression started while busy");

  a_mod_range: assert property (@(posedge clk) disable iff (rst) mod_done |-> (mod_rem < n))
    else $error("slot index out of range");

  a_block_full: assert property (@(posedge clk) disable iff (rst)
      (in_acc && has_byte && pos == 7'd127) |=> core_start)
    else $error("full block not compressed");

  a_back_to_in: assert property (@(posedge clk) disable iff (rst)
      (out_acc && last_word) |=> !in_stall)
    else $error("input not reopened after last key word");

  a_no_rw_mix: assert property (@(posedge clk) disable iff (rst) rv |-> !ram_we)
    else $error("slot write during slot read");

endmodule
`default_nettype wire

// File: hw/rtl/romix_ram.sv
// Generic single-write, registered-read RAM.
`default_nettype none
module romix_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8192
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: hw/rtl/romix_sha.sv
// Iterative SHA-512 compression, one round per cycle.
`default_nettype none
module romix_sha (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire romix_pkg::state_t st_in,
  input  wire romix_pkg::block_t blk_in,
  output logic                   busy,
  output logic                   done,
  output romix_pkg::state_t      digest
);
  import romix_pkg::*;

  logic   run;
  logic   fin;
  logic [6:0] cnt;
  state_t v;
  state_t st0;
  block_t win;

  word_t s1, ch, t1, s0, maj, t2, ws0, ws1, wn;
  state_t v_next;

  always_comb begin
    s1  = rotr(v[4], 14) ^ rotr(v[4], 18) ^ rotr(v[4], 41);
    ch  = (v[4] & v[5]) ^ (~v[4] & v[6]);
    t1  = v[7] + s1 + ch + K_TAB[cnt] + win[0];
    s0  = rotr(v[0], 28) ^ rotr(v[0], 34) ^ rotr(v[0], 39);
    maj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
    t2  = s0 + maj;
    v_next = {v[6], v[5], v[4], v[3] + t1, v[2], v[1], v[0], t1 + t2};
    ws0 = rotr(win[1], 1) ^ rotr(win[1], 8) ^ (win[1] >> 7);
    ws1 = rotr(win[14], 19) ^ rotr(win[14], 61) ^ (win[14] >> 6);
    wn  = win[0] + ws0 + win[9] + ws1;
  end

  assign busy = run | fin;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        run <= 1'b1;
        cnt <= '0;
        v   <= st_in;
        st0 <= st_in;
        win <= blk_in;
      end else if (run) begin
        v   <= v_next;
        win <= {wn, win[15:1]};
        cnt <= cnt + 7'd1;
        if (cnt == 7'd79) begin
          run <= 1'b0;
          fin <= 1'b1;
        end
      end else if (fin) begin
        for (int i = 0; i < 8; i++) begin
          digest[i] <= st0[i] + v[i];
        end
        fin  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/romix_mod.sv
// Bit-serial 32-bit remainder by a variable divisor.
`default_nettype none
module romix_mod #(
  parameter int NW = 11
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [31:0]   num,
  input  wire logic [NW-1:0] den,
  output logic               done,
  output logic [NW-1:0]      rem
);

  logic          run;
  logic [4:0]    cnt;
  logic [31:0]   q;
  logic [NW:0]   part;
  logic [NW:0]   trial;

  assign trial = {part[NW-1:0], q[31]};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start && !run) begin
        run  <= 1'b1;
        cnt  <= '0;
        q    <= num;
        part <= '0;
      end else if (run) begin
        q <= q << 1;
        if (trial >= {1'b0, den}) begin
          part <= trial - {1'b0, den};
        end else begin
          part <= trial;
        end
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rem = part[NW-1:0];

endmodule
`default_nettype wire

// File: test/romix_kdf_checker.sv
// Checker for the ROMix SHA-512 key derivation: watches all channels, predicts key words, compares.
module romix_kdf_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        has_byte,
  input  logic [7:0]  password_byte,
  input  logic        end_of_password,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [63:0] key_word,
  input  logic [1:0]  word_index,
  input  logic        last_word,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  output int          errors,
  output int          pending
);
  import romix_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_SLOTS = 1024;

  typedef struct packed {
    word_t      key;
    logic [1:0] idx;
    logic       last;
  } key_item_t;

  key_item_t   key_q[$];
  word_t       salt[4];
  logic [10:0] seq_reg;
  logic [31:0] iter_reg;
  state_t      hs;
  block_t      blk;
  logic [63:0] msg_len;
  word_t       slots[0:MAX_SLOTS*8-1];
  int          mismatches = 0;

  assign errors  = mismatches;
  assign pending = key_q.size();

  function automatic word_t ror(word_t x, int unsigned n);
    return (x >> n) | (x << (64 - n));
  endfunction

  function automatic state_t sha_compress(state_t st, block_t b);
    word_t  w[80];
    word_t  s0, s1, t1, t2;
    state_t v;
    int     i;
    for (i = 0; i < 16; i++) w[i] = b[i];
    for (i = 16; i < 80; i++) begin
      s0 = ror(w[i-15], 1) ^ ror(w[i-15], 8) ^ (w[i-15] >> 7);
      s1 = ror(w[i-2], 19) ^ ror(w[i-2], 61) ^ (w[i-2] >> 6);
      w[i] = w[i-16] + s0 + w[i-7] + s1;
    end
    v = st;
    for (i = 0; i < 80; i++) begin
      t1 = v[7] + (ror(v[4], 14) ^ ror(v[4], 18) ^ ror(v[4], 41))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + K_TAB[i] + w[i];
      t2 = (ror(v[0], 28) ^ ror(v[0], 34) ^ ror(v[0], 39))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (i = 0; i < 8; i++) st[i] = st[i] + v[i];
    return st;
  endfunction

  function automatic state_t hash_64byte(state_t x);
    block_t b;
    int     i;
    b = '0;
    for (i = 0; i < 8; i++) b[i] = x[i];
    b[8]  = 64'h8000000000000000;
    b[15] = 64'd512;
    return sha_compress(INIT_HASH, b);
  endfunction

  task automatic put_byte(logic [7:0] v);
    int pos;
    pos = msg_len[6:0];
    blk[pos >> 3][(7 - (pos & 7)) * 8 +: 8] = v;
    if (pos == 127) begin
      hs  = sha_compress(hs, blk);
      blk = '0;
    end
  endtask

  task automatic absorb(logic [7:0] v);
    put_byte(v);
    msg_len = msg_len + 1;
  endtask

  task automatic restart_hash();
    hs      = INIT_HASH;
    blk     = '0;
    msg_len = '0;
  endtask

  task automatic derive_key();
    int unsigned     n, s, w, r, k, pos;
    longint unsigned it, iters;
    logic [31:0]     lo, idx;
    logic [63:0]     total;
    state_t          cv, m, t;
    key_item_t       item;
    for (k = 0; k < 32; k++) absorb(salt[k / 8][(7 - (k % 8)) * 8 +: 8]);
    total = msg_len;
    pos   = total[6:0];
    put_byte(8'h80);
    if (pos >= 112) begin
      if (pos != 127) hs = sha_compress(hs, blk);
      blk = '0;
    end
    blk[14] = total >> 61;
    blk[15] = total << 3;
    hs = sha_compress(hs, blk);
    cv = hs;
    n = seq_reg;
    if (n == 0) n = 1;
    if (n > MAX_SLOTS) n = MAX_SLOTS;
    iters = (iter_reg == 0) ? 1 : iter_reg;
    for (it = 0; it < iters; it++) begin
      if (it != 0) begin
        for (k = 0; k < 4; k++) begin
          m[k]     = cv[k];
          m[k + 4] = salt[k];
        end
        cv = hash_64byte(m);
      end
      for (w = 0; w < 8; w++) slots[w] = cv[w];
      t = cv;
      for (s = 1; s < n; s++) begin
        t = hash_64byte(t);
        for (w = 0; w < 8; w++) slots[s * 8 + w] = t[w];
      end
      cv = t;
      for (r = 0; r < n / 2; r++) begin
        lo  = cv[7][31:0];
        idx = {lo[7:0], lo[15:8], lo[23:16], lo[31:24]} % n;
        for (w = 0; w < 8; w++) m[w] = cv[w] ^ slots[idx * 8 + w];
        cv = hash_64byte(m);
      end
    end
    for (k = 0; k < 4; k++) begin
      item.key  = cv[k];
      item.idx  = k;
      item.last = (k == 3);
      key_q.push_back(item);
    end
    restart_hash();
  endtask

  always @(posedge clk) begin
    key_item_t exp_item;
    if (rst) begin
      for (int i = 0; i < 4; i++) salt[i] = '0;
      seq_reg  = 11'd16;
      iter_reg = 32'd1;
      restart_hash();
      key_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SALT0, CFG_SALT1, CFG_SALT2, CFG_SALT3: salt[cfg_index] = cfg_data;
          CFG_SEQ:  seq_reg  = cfg_data[10:0];
          CFG_ITER: iter_reg = cfg_data[31:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        if (has_byte) absorb(password_byte);
        if (end_of_password) derive_key();
      end
      if (out_valid && !out_stall) begin
        if (key_q.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: unexpected key word %h idx %0d last %0b",
                     $realtime, key_word, word_index, last_word);
          mismatches++;
        end else begin
          exp_item = key_q.pop_front();
          if (key_word !== exp_item.key || word_index !== exp_item.idx ||
              last_word !== exp_item.last) begin
            if (mismatches < 10)
              $display("%0t: key word mismatch exp %h/%0d/%0b got %h/%0d/%0b", $realtime,
                       exp_item.key, exp_item.idx, exp_item.last,
                       key_word, word_index, last_word);
            mismatches++;
          end
        end
      end
    end
  end

endmodule

// File: test/romix_sha512_key_derivation_top_tb.sv
// Testbench top for the ROMix SHA-512 key derivation: stimulus, idling modes and verdict.
module romix_sha512_key_derivation_top_tb;
  import romix_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] CFG_SPARE_LO = 3'd6;
  localparam logic [2:0] CFG_SPARE_HI = 3'd7;
  localparam int QUIET_LIMIT = 600000;
  localparam int PHASE_ITEMS = 16;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        has_byte = 1'b0;
  logic [7:0]  password_byte = '0;
  logic        end_of_password = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] key_word;
  logic [1:0]  word_index;
  logic        last_word;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;
  int          errors, pending;
  int          snd_pct = 0, rcv_pct = 0;
  int          quiet = 0;
  int          phase_items;

  always #10 clk = ~clk;

  romix_sha512_key_derivation_top dut (.*);

  romix_kdf_checker chk (.*);

  always @(posedge clk) out_stall <= rst ? 1'b0 : ($urandom_range(99) < rcv_pct);

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  task automatic send_item(logic hb, logic [7:0] b, logic eop);
    in_valid        <= 1'b1;
    has_byte        <= hb;
    password_byte   <= b;
    end_of_password <= eop;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    phase_items++;
    if ($urandom_range(99) < snd_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic in_pause();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_idle();
    in_pause();
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic cfg_write(logic [2:0] idx, logic [63:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic cfg_release();
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_config();
    logic [63:0] seq;
    cfg_write(CFG_SALT0, {$urandom, $urandom});
    cfg_write(CFG_SALT1, {$urandom, $urandom});
    cfg_write(CFG_SALT2, {$urandom, $urandom});
    cfg_write(CFG_SALT3, {$urandom, $urandom});
    case ($urandom_range(7))
      0: seq = 0;
      1: seq = $urandom_range(10, 40);
      default: seq = $urandom_range(1, 9);
    endcase
    cfg_write(CFG_SEQ, seq);
    cfg_write(CFG_ITER, $urandom_range(0, 3));
    cfg_release();
  endtask

  task automatic send_password();
    int len;
    bit bare;
    case ($urandom_range(11))
      0: len = $urandom_range(80, 95);
      1: len = $urandom_range(128, 140);
      default: len = $urandom_range(0, 10);
    endcase
    bare = (len == 0) || ($urandom_range(3) == 0);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(11) == 0) send_item(1'b0, $urandom_range(255), 1'b0);
      send_item(1'b1, $urandom_range(255), (i == len - 1) && !bare);
    end
    if (bare) send_item(1'b0, $urandom_range(255), 1'b1);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings, empty password
    send_item(1'b0, 8'hA5, 1'b1);
    wait_idle();

    cfg_write(CFG_SALT0, '1);
    cfg_write(CFG_SALT1, '1);
    cfg_write(CFG_SALT2, '1);
    cfg_write(CFG_SALT3, '1);
    cfg_write(CFG_SEQ, 64'd1);
    cfg_write(CFG_ITER, 64'd0);
    cfg_write(CFG_SPARE_LO, {$urandom, $urandom});
    cfg_write(CFG_SPARE_HI, {$urandom, $urandom});
    cfg_release();
    send_item(1'b1, 8'h00, 1'b0);
    send_item(1'b1, 8'hFF, 1'b0);
    send_item(1'b1, 8'h5A, 1'b1);
    wait_idle();

    cfg_write(CFG_SALT0, '0);
    cfg_write(CFG_SALT1, '0);
    cfg_write(CFG_SALT2, '0);
    cfg_write(CFG_SALT3, '0);
    cfg_write(CFG_SEQ, 64'd0);
    cfg_write(CFG_ITER, 64'd2);
    cfg_release();
    send_item(1'b1, 8'h41, 1'b0);
    send_item(1'b0, 8'h3C, 1'b0);
    send_item(1'b1, 8'h42, 1'b0);
    send_item(1'b0, 8'hC3, 1'b1);
    wait_idle();

    // sequence count above the table size saturates
    cfg_write(CFG_SALT2, {$urandom, $urandom});
    cfg_write(CFG_SEQ, 64'd2047);
    cfg_write(CFG_ITER, 64'd1);
    cfg_release();
    send_item(1'b1, 8'h80, 1'b1);
    wait_idle();

    cfg_write(CFG_SEQ, 64'd1024);
    cfg_write(CFG_ITER, 64'hFFFFFFFF);
    cfg_write(CFG_ITER, 64'd3);
    cfg_write(CFG_SEQ, 64'd3);
    cfg_release();
    send_item(1'b1, 8'h01, 1'b0);
    wait_idle();
    // salt change in the middle of a password
    cfg_write(CFG_SALT0, {$urandom, $urandom});
    cfg_release();
    send_item(1'b1, 8'h7F, 1'b1);
    wait_idle();

    for (int ph = 0; ph < 3; ph++) begin
      snd_pct = (ph == 0) ? 12 : (ph == 1) ? 87 : 0;
      rcv_pct = (ph == 0) ? 87 : (ph == 1) ? 12 : 0;
      phase_items = 0;
      random_config();
      send_password();
      wait_idle();
      while (phase_items < PHASE_ITEMS) begin
        if ($urandom_range(3) == 0) begin
          wait_idle();
          random_config();
        end
        send_password();
      end
      wait_idle();
    end

    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
